FILE: rtl/dtt_pkg.sv
// Shared types, constants and register indexes of the delimited text tokenizer.
`default_nettype none
package dtt_pkg;

  // Character width of the stream and of the character registers.
  localparam int CHAR_W = 16;
  // Width of the configuration write data and of the length limit.
  localparam int CFG_W = 16;
  // Raw field length counter width; it can run slightly past the limit.
  localparam int LEN_W = 17;
  // Configuration index width.
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAL_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAL_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_A  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_B  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 3'd6;

  localparam logic [CHAR_W-1:0] DELIM_RST = CHAR_W'(44);
  localparam logic [CHAR_W-1:0] QUAL_RST  = CHAR_W'(34);
  localparam logic [CHAR_W-1:0] LINE_RST  = CHAR_W'(10);
  localparam logic [CFG_W-1:0]  MAX_LEN_RST = CFG_W'(16384);

  localparam logic [CHAR_W-1:0] CH_CR    = CHAR_W'(13);
  localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);

  // Configuration register set.
  typedef struct packed {
    logic [CHAR_W-1:0] delim_a;
    logic [CHAR_W-1:0] delim_b;
    logic [CHAR_W-1:0] qual_a;
    logic [CHAR_W-1:0] qual_b;
    logic [CHAR_W-1:0] line_a;
    logic [CHAR_W-1:0] line_b;
    logic [CFG_W-1:0]  max_len;
  } cfg_t;

  // One classified input beat.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eoi;
    logic              is_sep;
    logic              is_line;
    logic              is_qual;
    logic              is_cr;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              char_valid;
    logic              field_end;
    logic              row_end;
    logic              truncated;
    logic              stream_done;
    logic              last;
  } res_t;

  // Results of one step, handed to the output queue.
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      r;
  } push_t;

endpackage
`default_nettype wire

FILE: rtl/delimited_text_tokenizer_top.sv
// Top level of the delimited text tokenizer with its configuration registers.
`default_nettype none
// Takes one text character per input beat, or an end-of-input mark, and returns field
// characters with field and row end marks, one result beat per cycle while out_ready
// is high. The step engine applies each beat to the parse state; beats giving at most
// one result flow at one beat per cycle unless the output is held, and a beat giving
// two results sends them as two beats. Beats are registered in the input queue and
// results in the output queue. Registers are to be written through the cfg port by the
// user only while no beat is in flight; the block itself does not enforce this.
module delimited_text_tokenizer_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [dtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [dtt_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [dtt_pkg::CHAR_W-1:0]  in_char,
  input  wire                         in_end_of_input,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [dtt_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_char_valid,
  output logic                        out_field_end,
  output logic                        out_row_end,
  output logic                        out_field_truncated,
  output logic                        out_stream_done,
  output logic                        out_last
);

  dtt_pkg::cfg_t  cfg_r;
  logic           q_valid, q_pop, space_ok;
  dtt_pkg::beat_t q_beat;
  dtt_pkg::push_t push;
  dtt_pkg::res_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_a <= dtt_pkg::DELIM_RST;
      cfg_r.delim_b <= dtt_pkg::DELIM_RST;
      cfg_r.qual_a  <= dtt_pkg::QUAL_RST;
      cfg_r.qual_b  <= dtt_pkg::QUAL_RST;
      cfg_r.line_a  <= dtt_pkg::LINE_RST;
      cfg_r.line_b  <= dtt_pkg::LINE_RST;
      cfg_r.max_len <= dtt_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtt_pkg::CFG_DELIM_A: cfg_r.delim_a <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_DELIM_B: cfg_r.delim_b <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_QUAL_A:  cfg_r.qual_a  <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_QUAL_B:  cfg_r.qual_b  <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_LINE_A:  cfg_r.line_a  <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_LINE_B:  cfg_r.line_b  <= cfg_wdata[dtt_pkg::CHAR_W-1:0];
        dtt_pkg::CFG_MAX_LEN: cfg_r.max_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dtt_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char(in_char), .in_end_of_input(in_end_of_input),
    .q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop)
  );

  dtt_core u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_beat(q_beat), .q_pop(q_pop),
    .space_ok(space_ok), .push(push)
  );

  dtt_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(push), .space_ok(space_ok),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_char            = res.ch;
  assign out_char_valid      = res.char_valid;
  assign out_field_end       = res.field_end;
  assign out_row_end         = res.row_end;
  assign out_field_truncated = res.truncated;
  assign out_stream_done     = res.stream_done;
  assign out_last            = res.last;

endmodule
`default_nettype wire

FILE: rtl/dtt_front.sv
// Input queue that takes character beats and classifies them against the registers.
`default_nettype none
module dtt_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  dtt_pkg::cfg_t          cfg,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [dtt_pkg::CHAR_W-1:0]   in_char,
  input  wire                          in_end_of_input,
  output logic                         q_valid,
  output dtt_pkg::beat_t               q_beat,
  input  wire                          q_pop
);

  dtt_pkg::beat_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  dtt_pkg::beat_t b_in;
  logic           push;

  // Classify the incoming character.
  always_comb begin
    b_in.ch       = in_char;
    b_in.eoi      = in_end_of_input;
    b_in.is_sep   = (in_char == cfg.delim_a) || (in_char == cfg.delim_b);
    b_in.is_line  = (in_char == cfg.line_a) || (in_char == cfg.line_b);
    b_in.is_qual  = (in_char == cfg.qual_a) || (in_char == cfg.qual_b);
    b_in.is_cr    = (in_char == dtt_pkg::CH_CR);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_beat   = mem_r[rp_r];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= b_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtt_core.sv
// Tokenizer step engine: applies one beat to the parse state and forms its results.
`default_nettype none
module dtt_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  dtt_pkg::cfg_t  cfg,
  input  wire                  q_valid,
  input  wire  dtt_pkg::beat_t q_beat,
  output logic                 q_pop,
  input  wire                  space_ok,
  output dtt_pkg::push_t       push
);

  typedef struct packed {
    logic                        in_quotes;
    logic [dtt_pkg::CHAR_W-1:0]  oqc;
    logic [dtt_pkg::CHAR_W-1:0]  lsc;
    logic                        cqp;
    logic [dtt_pkg::LEN_W-1:0]   rawlen;
    logic                        skip;
    logic                        fiq;
    logic [dtt_pkg::CHAR_W-1:0]  tqc;
    logic [dtt_pkg::CHAR_W-1:0]  held_char;
    logic                        held_valid;
    logic                        row_open;
    logic                        tr_started;
    logic                        tr_open;
    logic                        tr_match;
    logic                        trunc;
  } state_t;

  typedef struct packed {
    state_t              s;
    logic [1:0]          n;
    dtt_pkg::res_t [1:0] r;
  } ctx_t;

  state_t st_r, st_nxt;
  ctx_t   x;

  function automatic logic isq(logic [dtt_pkg::CHAR_W-1:0] c, dtt_pkg::cfg_t g);
    return (c == g.qual_a) || (c == g.qual_b);
  endfunction

  function automatic logic isd(logic [dtt_pkg::CHAR_W-1:0] c, dtt_pkg::cfg_t g);
    return (c == g.delim_a) || (c == g.delim_b);
  endfunction

  function automatic logic isl(logic [dtt_pkg::CHAR_W-1:0] c, dtt_pkg::cfg_t g);
    return (c == g.line_a) || (c == g.line_b);
  endfunction

  // Add a character result; further results past two are dropped.
  function automatic ctx_t emit(ctx_t y, logic [dtt_pkg::CHAR_W-1:0] c);
    dtt_pkg::res_t e;
    e = '0;
    e.ch = c;
    e.char_valid = 1'b1;
    if (y.n == 2'd0) begin
      y.r[0] = e;
      y.n = 2'd1;
    end else if (y.n == 2'd1) begin
      y.r[1] = e;
      y.n = 2'd2;
    end
    return y;
  endfunction

  function automatic ctx_t clear_field(ctx_t y);
    y.s.rawlen     = '0;
    y.s.held_valid = 1'b0;
    y.s.held_char  = '0;
    y.s.tr_started = 1'b0;
    y.s.fiq        = 1'b0;
    y.s.tr_open    = 1'b0;
    y.s.tr_match   = 1'b0;
    y.s.tqc        = '0;
    return y;
  endfunction

  // Field cleaning: outer qualifiers, doubled qualifiers and NUL.
  function automatic ctx_t feed(ctx_t y, logic [dtt_pkg::CHAR_W-1:0] c, dtt_pkg::cfg_t g);
    logic q;
    q = isq(c, g);
    if (!y.s.tr_started) begin
      y.s.tr_started = 1'b1;
      y.s.fiq = q;
    end
    if (!y.s.fiq) return emit(y, c);
    if (y.s.tr_match) begin
      y.s.tr_match = 1'b0;
      if (q) return emit(y, y.s.tqc);
      y.s.tr_open = 1'b0;
    end
    if (q) begin
      if (y.s.tr_open && (y.s.tqc == c)) begin
        y.s.tr_match = 1'b1;
        return y;
      end
      if (!y.s.tr_open) begin
        y.s.tr_open = 1'b1;
        y.s.tqc = c;
        return y;
      end
    end
    return emit(y, (c == '0) ? dtt_pkg::CH_SPACE : c);
  endfunction

  // Append one raw character; a CR is held until the next one shows it is not trailing.
  function automatic ctx_t raw_append(ctx_t y, logic [dtt_pkg::CHAR_W-1:0] c, dtt_pkg::cfg_t g);
    y.s.rawlen = y.s.rawlen + dtt_pkg::LEN_W'(1);
    if (y.s.held_valid) begin
      y.s.held_valid = 1'b0;
      y = feed(y, y.s.held_char, g);
    end
    if (c == dtt_pkg::CH_CR) begin
      y.s.held_char = c;
      y.s.held_valid = 1'b1;
    end else begin
      y = feed(y, c, g);
    end
    return y;
  endfunction

  function automatic ctx_t end_field(ctx_t y, logic row);
    if ((y.s.rawlen == dtt_pkg::LEN_W'(1)) && y.s.tr_started && y.s.fiq) begin
      y = emit(y, y.s.tqc);
    end
    if (y.n == 2'd0) begin
      y.r[0] = '0;
      y.n = 2'd1;
    end
    if (y.n == 2'd1) begin
      y.r[0].field_end = 1'b1;
      y.r[0].row_end   = row;
      y.r[0].truncated = y.s.trunc;
    end else begin
      y.r[1].field_end = 1'b1;
      y.r[1].row_end   = row;
      y.r[1].truncated = y.s.trunc;
    end
    y.s.trunc = 1'b0;
    return clear_field(y);
  endfunction

  // Delimiter, line and qualifier handling of one character.
  function automatic ctx_t parse_char(ctx_t y, dtt_pkg::beat_t b, dtt_pkg::cfg_t g);
    if (!y.s.in_quotes && b.is_line) begin
      y = end_field(y, 1'b1);
      y.s.row_open = 1'b0;
      y.s.skip = 1'b1;
      return y;
    end
    if (!y.s.in_quotes && b.is_sep) begin
      y = end_field(y, 1'b0);
    end else begin
      y = raw_append(y, b.ch, g);
      if (b.is_qual) begin
        if (y.s.in_quotes && (y.s.oqc == b.ch)) begin
          y.s.cqp = 1'b1;
        end else if (!y.s.in_quotes && (isd(y.s.lsc, g) || isl(y.s.lsc, g))) begin
          y.s.in_quotes = 1'b1;
          y.s.oqc = b.ch;
        end
      end
    end
    if (b.ch != dtt_pkg::CH_SPACE) y.s.lsc = b.ch;
    return y;
  endfunction

  function automatic ctx_t take_char(ctx_t y, dtt_pkg::beat_t b, dtt_pkg::cfg_t g);
    if (y.s.skip) begin
      if (b.is_line) return y;
      y.s.skip = 1'b0;
    end
    if (!y.s.row_open) begin
      y.s.row_open  = 1'b1;
      y.s.in_quotes = 1'b0;
      y.s.cqp       = 1'b0;
      y.s.lsc       = g.line_a;
    end
    // A closing qualifier is confirmed or taken back by its follower.
    if (y.s.cqp) begin
      y.s.cqp = 1'b0;
      if (b.ch == y.s.oqc) return raw_append(y, b.ch, g);
      if (!b.is_sep && !b.is_line && !b.is_cr) y = raw_append(y, y.s.oqc, g);
      else y.s.in_quotes = 1'b0;
    end
    // Over-long field restarts unquoted.
    if (y.s.rawlen > {1'b0, g.max_len}) begin
      y.s.in_quotes = 1'b0;
      y.s.trunc = 1'b1;
      y = clear_field(y);
    end
    return parse_char(y, b, g);
  endfunction

  function automatic ctx_t eoi_step(ctx_t y, dtt_pkg::cfg_t g);
    if (y.s.row_open && !y.s.skip) begin
      y.s.cqp = 1'b0;
      y = end_field(y, 1'b1);
    end
    if (y.n == 2'd0) begin
      y.r[0] = '0;
      y.n = 2'd1;
    end
    if (y.n == 2'd1) y.r[0].stream_done = 1'b1;
    else y.r[1].stream_done = 1'b1;
    y.s.in_quotes = 1'b0;
    y.s.oqc       = '0;
    y.s.lsc       = g.line_a;
    y.s.cqp       = 1'b0;
    y.s.skip      = 1'b0;
    y.s.row_open  = 1'b0;
    y.s.trunc     = 1'b0;
    return clear_field(y);
  endfunction

  assign q_pop = q_valid && space_ok;

  // One step per accepted beat.
  always_comb begin
    x.s = st_r;
    x.n = 2'd0;
    x.r = '0;
    if (q_beat.eoi) x = eoi_step(x, cfg);
    else x = take_char(x, q_beat, cfg);
    if (x.n == 2'd1) x.r[0].last = 1'b1;
    else if (x.n == 2'd2) x.r[1].last = 1'b1;
    st_nxt = x.s;
    push.r = x.r;
    push.n = q_pop ? x.n : 2'd0;
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{lsc: dtt_pkg::LINE_RST, default: '0};
    end else if (q_pop) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtt_outq.sv
// Output queue that takes up to two results a cycle and sends one beat a cycle while out_ready is high.
`default_nettype none
module dtt_outq (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  dtt_pkg::push_t        push,
  output logic                        space_ok,
  output logic                        out_valid,
  input  wire                         out_ready,
  output dtt_pkg::res_t               out_res
);

  dtt_pkg::res_t mem_r [4];
  logic [1:0]    wp_r, rp_r;
  logic [2:0]    cnt_r;
  logic          pop;

  assign space_ok  = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rp_r];

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wp_r] <= push.r[0];
    if (push.n == 2'd2) mem_r[wp_r + 2'd1] <= push.r[1];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push.n;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push.n} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtt_checker.sv
// Port-level checks of the tokenizer result stream, bound to the top level.
`default_nettype none
module dtt_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [dtt_pkg::CHAR_W-1:0]  out_char,
  input wire                        out_char_valid,
  input wire                        out_field_end,
  input wire                        out_row_end,
  input wire                        out_field_truncated,
  input wire                        out_stream_done
);

  // A row end always closes its field.
  a_row_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_field_end)
    else $error("row end without field end");

  // The truncated flag only comes with a field end.
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_truncated |-> out_field_end)
    else $error("truncated flag without field end");

  // A beat without a character carries a zero character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char == '0)
    else $error("character on a beat without char valid");

  // A waiting result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_char, out_char_valid,
      out_field_end, out_row_end, out_field_truncated, out_stream_done}))
    else $error("result beat changed while waiting");

endmodule

bind delimited_text_tokenizer_top dtt_checker u_chk (.*);
`default_nettype wire

FILE: tb/sv/tb_delimited_text_tokenizer_top.sv
// Self-checking testbench of the delimited text tokenizer top level.
`timescale 1ns / 100ps

module tb_delimited_text_tokenizer_top;

  typedef struct packed {
    logic [dtt_pkg::CHAR_W-1:0] ch;
    logic                       eoi;
  } text_beat_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [dtt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dtt_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [dtt_pkg::CHAR_W-1:0]    in_char = '0;
  logic                          in_end_of_input = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dtt_pkg::CHAR_W-1:0]    out_char;
  logic                          out_char_valid, out_field_end, out_row_end;
  logic                          out_field_truncated, out_stream_done, out_last;

  delimited_text_tokenizer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char(in_char), .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char(out_char), .out_char_valid(out_char_valid),
    .out_field_end(out_field_end), .out_row_end(out_row_end),
    .out_field_truncated(out_field_truncated), .out_stream_done(out_stream_done),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Shadow registers and tokenizer state of the predictor.
  dtt_pkg::cfg_t              shadow_cfg;
  logic                       p_in_quotes, p_close_pending, p_skip_lines;
  logic                       p_quoted_field, p_held_valid, p_row_open;
  logic [dtt_pkg::CHAR_W-1:0] p_open_qual, p_last_sig, p_xlate_qual, p_held_char;
  logic [dtt_pkg::LEN_W-1:0]  p_raw_len;
  logic                       p_started, p_xl_open, p_xl_match, p_trunc;
  dtt_pkg::res_t              step_res [2];
  int                         step_cnt;

  text_beat_t    pending_beats [$];
  dtt_pkg::res_t expected_results [$];
  int            error_count = 0;
  int            send_gap_max = 0, recv_gap_max = 0;
  logic          long_hold_go = 1'b0;
  int            idle_cycles = 0;

  function automatic logic is_sep(logic [dtt_pkg::CHAR_W-1:0] c);
    return c == shadow_cfg.delim_a || c == shadow_cfg.delim_b;
  endfunction
  function automatic logic is_line(logic [dtt_pkg::CHAR_W-1:0] c);
    return c == shadow_cfg.line_a || c == shadow_cfg.line_b;
  endfunction
  function automatic logic is_qual(logic [dtt_pkg::CHAR_W-1:0] c);
    return c == shadow_cfg.qual_a || c == shadow_cfg.qual_b;
  endfunction

  function automatic void open_result();
    if (step_cnt < 2) begin
      step_res[step_cnt] = '0;
      step_cnt++;
    end
  endfunction

  function automatic void give_char(logic [dtt_pkg::CHAR_W-1:0] c);
    if (step_cnt >= 2) return;
    open_result();
    step_res[step_cnt-1].ch = c;
    step_res[step_cnt-1].char_valid = 1'b1;
  endfunction

  function automatic void clear_field();
    p_raw_len = '0;
    p_held_valid = 1'b0;
    p_held_char = '0;
    p_started = 1'b0;
    p_quoted_field = 1'b0;
    p_xl_open = 1'b0;
    p_xl_match = 1'b0;
    p_xlate_qual = '0;
  endfunction

  // Field cleaning: strip outer qualifiers, collapse doubled ones, NUL to space.
  function automatic void clean_char(logic [dtt_pkg::CHAR_W-1:0] c);
    if (!p_started) begin
      p_started = 1'b1;
      p_quoted_field = is_qual(c);
    end
    if (!p_quoted_field) begin
      give_char(c);
      return;
    end
    if (p_xl_match) begin
      p_xl_match = 1'b0;
      if (is_qual(c)) begin
        give_char(p_xlate_qual);
        return;
      end
      p_xl_open = 1'b0;
    end
    if (is_qual(c)) begin
      if (p_xl_open && p_xlate_qual == c) begin
        p_xl_match = 1'b1;
        return;
      end
      if (!p_xl_open) begin
        p_xl_open = 1'b1;
        p_xlate_qual = c;
        return;
      end
    end
    give_char(c == '0 ? dtt_pkg::CH_SPACE : c);
  endfunction

  // A CR is held back until the next raw character shows it is not trailing.
  function automatic void append_raw(logic [dtt_pkg::CHAR_W-1:0] c);
    p_raw_len++;
    if (p_held_valid) begin
      p_held_valid = 1'b0;
      clean_char(p_held_char);
    end
    if (c == dtt_pkg::CH_CR) begin
      p_held_char = c;
      p_held_valid = 1'b1;
    end else begin
      clean_char(c);
    end
  endfunction

  function automatic void close_field(logic row);
    if (p_raw_len == 1 && p_started && p_quoted_field) give_char(p_xlate_qual);
    if (step_cnt == 0) open_result();
    step_res[step_cnt-1].field_end = 1'b1;
    step_res[step_cnt-1].row_end = row;
    step_res[step_cnt-1].truncated = p_trunc;
    p_trunc = 1'b0;
    clear_field();
  endfunction

  function automatic void parse_one(logic [dtt_pkg::CHAR_W-1:0] c);
    if (!p_in_quotes && is_line(c)) begin
      close_field(1'b1);
      p_row_open = 1'b0;
      p_skip_lines = 1'b1;
      return;
    end
    if (!p_in_quotes && is_sep(c)) begin
      close_field(1'b0);
    end else begin
      append_raw(c);
      if (is_qual(c)) begin
        if (p_in_quotes && p_open_qual == c) begin
          p_close_pending = 1'b1;
        end else if (!p_in_quotes && (is_sep(p_last_sig) || is_line(p_last_sig))) begin
          p_in_quotes = 1'b1;
          p_open_qual = c;
        end
      end
    end
    if (c != dtt_pkg::CH_SPACE) p_last_sig = c;
  endfunction

  function automatic void restart_stream();
    p_in_quotes = 1'b0;
    p_open_qual = '0;
    p_last_sig = shadow_cfg.line_a;
    p_close_pending = 1'b0;
    p_skip_lines = 1'b0;
    p_row_open = 1'b0;
    p_trunc = 1'b0;
    clear_field();
  endfunction

  function automatic void take_text(logic [dtt_pkg::CHAR_W-1:0] c);
    if (p_skip_lines) begin
      if (is_line(c)) return;
      p_skip_lines = 1'b0;
    end
    if (!p_row_open) begin
      p_row_open = 1'b1;
      p_in_quotes = 1'b0;
      p_close_pending = 1'b0;
      p_last_sig = shadow_cfg.line_a;
    end
    if (p_close_pending) begin
      p_close_pending = 1'b0;
      if (c == p_open_qual) begin
        append_raw(c);
        return;
      end
      if (!is_sep(c) && !is_line(c) && c != dtt_pkg::CH_CR) append_raw(p_open_qual);
      else p_in_quotes = 1'b0;
    end
    // Over-long field restarts unquoted and gets flagged.
    if (p_raw_len > dtt_pkg::LEN_W'(shadow_cfg.max_len)) begin
      p_in_quotes = 1'b0;
      p_trunc = 1'b1;
      clear_field();
    end
    parse_one(c);
  endfunction

  // Applies one accepted beat and queues the results it causes.
  function automatic void tokenize_beat(text_beat_t b);
    step_cnt = 0;
    if (b.eoi) begin
      if (p_row_open && !p_skip_lines) begin
        p_close_pending = 1'b0;
        close_field(1'b1);
      end
      if (step_cnt == 0) open_result();
      step_res[step_cnt-1].stream_done = 1'b1;
      restart_stream();
    end else begin
      take_text(b.ch);
    end
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
    for (int k = 0; k < step_cnt; k++) expected_results.push_back(step_res[k]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: offers pending beats with random gaps.
  int         send_gap = 0;
  text_beat_t cur_beat;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) tokenize_beat(cur_beat);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_char <= cur_beat.ch;
          in_end_of_input <= cur_beat.eoi;
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, an occasional long hold, and the checks.
  int            recv_gap = 0, hold_left = 0;
  dtt_pkg::res_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", out_char, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_char != want.ch) report_mismatch("out_char", out_char, want.ch);
        if (out_char_valid != want.char_valid)
          report_mismatch("char_valid", out_char_valid, want.char_valid);
        if (out_field_end != want.field_end)
          report_mismatch("field_end", out_field_end, want.field_end);
        if (out_row_end != want.row_end) report_mismatch("row_end", out_row_end, want.row_end);
        if (out_field_truncated != want.truncated)
          report_mismatch("field_truncated", out_field_truncated, want.truncated);
        if (out_stream_done != want.stream_done)
          report_mismatch("stream_done", out_stream_done, want.stream_done);
        if (out_last != want.last) report_mismatch("last", out_last, want.last);
      end
      recv_gap = $urandom_range(0, recv_gap_max);
    end
    if (long_hold_go) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL delimited_text_tokenizer_top");
      $finish;
    end
  end

  task automatic add_char(logic [dtt_pkg::CHAR_W-1:0] c);
    pending_beats.push_back('{ch: c, eoi: 1'b0});
  endtask

  task automatic add_eoi();
    pending_beats.push_back('{ch: dtt_pkg::CHAR_W'($urandom), eoi: 1'b1});
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [dtt_pkg::CFG_IDX_W-1:0] idx, logic [dtt_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      dtt_pkg::CFG_DELIM_A: shadow_cfg.delim_a = val;
      dtt_pkg::CFG_DELIM_B: shadow_cfg.delim_b = val;
      dtt_pkg::CFG_QUAL_A:  shadow_cfg.qual_a = val;
      dtt_pkg::CFG_QUAL_B:  shadow_cfg.qual_b = val;
      dtt_pkg::CFG_LINE_A:  shadow_cfg.line_a = val;
      dtt_pkg::CFG_LINE_B:  shadow_cfg.line_b = val;
      dtt_pkg::CFG_MAX_LEN: shadow_cfg.max_len = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cfg(logic [dtt_pkg::CHAR_W-1:0] da, db, qa, qb, la, lb,
                          logic [dtt_pkg::CFG_W-1:0] ml);
    write_reg(dtt_pkg::CFG_DELIM_A, da);
    write_reg(dtt_pkg::CFG_DELIM_B, db);
    write_reg(dtt_pkg::CFG_QUAL_A, qa);
    write_reg(dtt_pkg::CFG_QUAL_B, qb);
    write_reg(dtt_pkg::CFG_LINE_A, la);
    write_reg(dtt_pkg::CFG_LINE_B, lb);
    write_reg(dtt_pkg::CFG_MAX_LEN, ml);
  endtask

  // Any character, leaning on the ones the tokenizer treats specially.
  function automatic logic [dtt_pkg::CHAR_W-1:0] any_char();
    case ($urandom_range(0, 11))
      0: return shadow_cfg.delim_a;
      1: return shadow_cfg.delim_b;
      2: return shadow_cfg.qual_a;
      3: return shadow_cfg.qual_b;
      4: return shadow_cfg.line_a;
      5: return shadow_cfg.line_b;
      6: return dtt_pkg::CH_CR;
      7: return dtt_pkg::CH_SPACE;
      8: return '0;
      9: return dtt_pkg::CHAR_W'($urandom);
      default: return dtt_pkg::CHAR_W'($urandom_range(97, 122));
    endcase
  endfunction

  // Field content; mostly letters, with some full-width random characters.
  function automatic logic [dtt_pkg::CHAR_W-1:0] text_char();
    if ($urandom_range(0, 3) == 0) return dtt_pkg::CHAR_W'($urandom);
    return dtt_pkg::CHAR_W'($urandom_range(97, 122));
  endfunction

  // One well-formed row with random content, now and then broken by noise.
  task automatic add_row();
    int nf;
    logic [dtt_pkg::CHAR_W-1:0] q;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) add_char($urandom_range(0, 1) ? shadow_cfg.delim_a : shadow_cfg.delim_b);
      if ($urandom_range(0, 4) == 0) add_char(dtt_pkg::CH_SPACE);
      if ($urandom_range(0, 1)) begin
        q = $urandom_range(0, 1) ? shadow_cfg.qual_a : shadow_cfg.qual_b;
        add_char(q);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 7))
            0: begin add_char(q); add_char(q); end
            1: add_char(shadow_cfg.delim_a);
            2: add_char(shadow_cfg.line_a);
            3: add_char('0);
            default: add_char(text_char());
          endcase
        end
        add_char(q);
      end else begin
        repeat ($urandom_range(0, 5)) add_char(text_char());
      end
      if ($urandom_range(0, 6) == 0) add_char(any_char());
    end
    if ($urandom_range(0, 3) == 0) add_char(dtt_pkg::CH_CR);
    add_char($urandom_range(0, 1) ? shadow_cfg.line_a : shadow_cfg.line_b);
    if ($urandom_range(0, 4) == 0) add_char(shadow_cfg.line_b);
    if ($urandom_range(0, 9) == 0) add_eoi();
  endtask

  task automatic random_phase(int n);
    send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    while (pending_beats.size() < n) begin
      if ($urandom_range(0, 5) == 0) add_char(any_char());
      else add_row();
    end
    add_eoi();
    drain();
  endtask

  initial begin
    shadow_cfg = '{delim_a: dtt_pkg::DELIM_RST, delim_b: dtt_pkg::DELIM_RST,
                   qual_a: dtt_pkg::QUAL_RST, qual_b: dtt_pkg::QUAL_RST,
                   line_a: dtt_pkg::LINE_RST, line_b: dtt_pkg::LINE_RST,
                   max_len: dtt_pkg::MAX_LEN_RST};
    restart_stream();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty row first, quoted field with doubled qualifier, empty
    // quoted field, trailing CR, stray qualifier, extreme characters.
    add_char(dtt_pkg::LINE_RST);
    add_char(16'h61); add_char(dtt_pkg::DELIM_RST);
    add_char(dtt_pkg::QUAL_RST); add_char(16'h62);
    add_char(dtt_pkg::QUAL_RST); add_char(dtt_pkg::QUAL_RST);
    add_char(16'h63); add_char(dtt_pkg::QUAL_RST); add_char(dtt_pkg::DELIM_RST);
    add_char(dtt_pkg::QUAL_RST); add_char(dtt_pkg::QUAL_RST);
    add_char(dtt_pkg::CH_CR); add_char(dtt_pkg::LINE_RST);
    add_char(16'h78); add_char(dtt_pkg::QUAL_RST); add_char(16'h0000); add_char(16'hFFFF);
    add_char(dtt_pkg::DELIM_RST); add_char(dtt_pkg::QUAL_RST);
    add_char(dtt_pkg::LINE_RST); add_char(dtt_pkg::LINE_RST);
    add_char(dtt_pkg::CH_CR); add_char(dtt_pkg::DELIM_RST);
    add_char(dtt_pkg::QUAL_RST); add_char(16'h00); add_char(dtt_pkg::QUAL_RST); add_eoi();
    add_eoi();
    drain();

    // Truncation with a limit of one; the long hold backs up the input.
    write_reg(dtt_pkg::CFG_MAX_LEN, 16'd1);
    send_gap_max = 0;
    recv_gap_max = 0;
    @(negedge clk) long_hold_go = 1'b1;
    @(negedge clk) long_hold_go = 1'b0;
    repeat (40) add_char(16'h41);
    add_char(dtt_pkg::QUAL_RST); add_char(16'h42); add_char(16'h43);
    add_char(dtt_pkg::QUAL_RST);
    add_eoi();
    drain();

    // Random phases over several register settings, the extremes among them.
    random_phase(250);
    load_cfg(16'h0000, 16'hFFFF, 16'h0000, 16'h0022, 16'hFFFF, 16'h000A, 16'd4);
    random_phase(250);
    load_cfg(16'hFFFF, 16'h003B, 16'hFFFF, 16'h0027, 16'h0000, 16'h000D, 16'hFFFF);
    random_phase(250);
    // A qualifier shared with a delimiter.
    load_cfg(16'h002C, 16'h0009, 16'h0022, 16'h002C, 16'h000A, 16'h000A, 16'd3);
    random_phase(250);
    load_cfg(16'h002C, 16'h002C, 16'h0022, 16'h0022, 16'h000A, 16'h000D, 16'd6);
    random_phase(250);
    load_cfg(16'h007C, 16'h002C, 16'h0027, 16'h0022, 16'h000A, 16'h0000, 16'd1);
    random_phase(320);

    if (error_count == 0) begin
      $display("PASS delimited_text_tokenizer_top");
    end else begin
      $display("FAIL delimited_text_tokenizer_top");
    end
    $finish;
  end

endmodule
